// ----- sv/hdu_pkg.sv -----
package hdu_pkg;

  localparam int unsigned DataBitsDefault   = 8;
  localparam int unsigned CntWidthDefault   = 16;
  localparam int unsigned BaudDivWidth      = 16;
  localparam int unsigned ByteWidth         = 8;
  localparam logic [BaudDivWidth-1:0] BaudDivReset = 16'd104;
  localparam int unsigned TxStartDelay      = 10;

  typedef struct packed {
    logic                 tx_line;
    logic                 tx_busy;
    logic                 rx_busy;
    logic                 rx_valid;
    logic [ByteWidth-1:0] rx_byte;
  } hdu_result_t;

endpackage

// ----- sv/hdu_engine.sv -----
module hdu_engine
  import hdu_pkg::*;
#(
  parameter int unsigned DATA_BITS          = DataBitsDefault,
  parameter int unsigned TICK_COUNTER_WIDTH = CntWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [BaudDivWidth-1:0] baud_div_i,
  input  logic                    rx_level_i,
  input  logic                    send_valid_i,
  input  logic [ByteWidth-1:0]    send_data_i,
  output hdu_result_t             result_o
);

  localparam int unsigned CW  = TICK_COUNTER_WIDTH;
  localparam int unsigned BLW = $clog2(DATA_BITS + 3);
  localparam int unsigned BIW = $clog2(DATA_BITS + 1);

  logic [DATA_BITS-1:0] tx_shift_q, tx_shift_d;
  logic [BLW-1:0]       tx_bits_left_q, tx_bits_left_d;
  logic                 tx_next_level_q, tx_next_level_d;
  logic [CW-1:0]        tx_cnt_q, tx_cnt_d;
  logic                 tx_level_q, tx_level_d;
  logic                 tx_active_q, tx_active_d;
  logic [DATA_BITS-1:0] rx_shift_q, rx_shift_d;
  logic [BIW-1:0]       rx_bit_index_q, rx_bit_index_d;
  logic [CW-1:0]        rx_cnt_q, rx_cnt_d;
  logic                 rx_active_q, rx_active_d;
  logic                 rx_prev_level_q, rx_prev_level_d;
  logic [DATA_BITS-1:0] rx_result_q, rx_result_d;
  logic                 rx_valid;

  logic [CW-1:0]              baud_div_cnt;
  logic [BaudDivWidth:0]      half_sum;
  logic [CW-1:0]              start_delay;
  logic [CW-1:0]              tx_cnt_dec;
  logic [CW-1:0]              rx_cnt_dec;
  logic                       accepted;

  assign baud_div_cnt = CW'(baud_div_i);
  assign half_sum     = {1'b0, baud_div_i} + {2'b00, baud_div_i[BaudDivWidth-1:1]};
  assign start_delay  = CW'(half_sum);
  assign tx_cnt_dec   = tx_cnt_q - CW'(1);
  assign rx_cnt_dec   = rx_cnt_q - CW'(1);

  always_comb begin
    tx_shift_d      = tx_shift_q;
    tx_bits_left_d  = tx_bits_left_q;
    tx_next_level_d = tx_next_level_q;
    tx_cnt_d        = tx_cnt_q;
    tx_level_d      = tx_level_q;
    tx_active_d     = tx_active_q;
    rx_shift_d      = rx_shift_q;
    rx_bit_index_d  = rx_bit_index_q;
    rx_cnt_d        = rx_cnt_q;
    rx_active_d     = rx_active_q;
    rx_result_d     = rx_result_q;
    rx_prev_level_d = rx_level_i;
    rx_valid        = 1'b0;
    accepted        = 1'b0;

    if (tx_active_q) begin
      tx_cnt_d = tx_cnt_dec;
      if (tx_cnt_dec == '0) begin
        tx_level_d = tx_next_level_q;
        if (tx_bits_left_q == '0) begin
          tx_active_d     = 1'b0;
          tx_next_level_d = 1'b0;
        end else begin
          tx_next_level_d = tx_shift_q[0] || (tx_bits_left_q <= BLW'(2));
          tx_shift_d      = tx_shift_q >> 1;
          tx_bits_left_d  = tx_bits_left_q - BLW'(1);
          tx_cnt_d        = baud_div_cnt;
        end
      end
    end else if (send_valid_i) begin
      accepted        = 1'b1;
      tx_active_d     = 1'b1;
      tx_shift_d      = send_data_i[DATA_BITS-1:0];
      tx_bits_left_d  = BLW'(DATA_BITS + 2);
      tx_next_level_d = 1'b0;
      tx_cnt_d        = CW'(TxStartDelay);
      rx_active_d     = 1'b0;
    end

    if (!accepted) begin
      if (rx_active_q) begin
        rx_cnt_d = rx_cnt_dec;
        if (rx_cnt_dec == '0) begin
          if (rx_bit_index_q < BIW'(DATA_BITS)) begin
            for (int i = 0; i < DATA_BITS; i++) begin
              if (rx_bit_index_q == BIW'(i) && rx_level_i) begin
                rx_shift_d[i] = 1'b1;
              end
            end
            rx_bit_index_d = rx_bit_index_q + BIW'(1);
            rx_cnt_d       = baud_div_cnt;
          end else begin
            rx_result_d = rx_shift_q;
            rx_valid    = 1'b1;
            rx_active_d = 1'b0;
          end
        end
      end else if (!tx_active_q && !tx_active_d && rx_prev_level_q && !rx_level_i) begin
        rx_active_d    = 1'b1;
        rx_shift_d     = '0;
        rx_bit_index_d = '0;
        rx_cnt_d       = start_delay;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_shift_q      <= '0;
      tx_bits_left_q  <= '0;
      tx_next_level_q <= 1'b0;
      tx_cnt_q        <= '0;
      tx_level_q      <= 1'b1;
      tx_active_q     <= 1'b0;
      rx_shift_q      <= '0;
      rx_bit_index_q  <= '0;
      rx_cnt_q        <= '0;
      rx_active_q     <= 1'b0;
      rx_prev_level_q <= 1'b1;
      rx_result_q     <= '0;
    end else if (step_i) begin
      tx_shift_q      <= tx_shift_d;
      tx_bits_left_q  <= tx_bits_left_d;
      tx_next_level_q <= tx_next_level_d;
      tx_cnt_q        <= tx_cnt_d;
      tx_level_q      <= tx_level_d;
      tx_active_q     <= tx_active_d;
      rx_shift_q      <= rx_shift_d;
      rx_bit_index_q  <= rx_bit_index_d;
      rx_cnt_q        <= rx_cnt_d;
      rx_active_q     <= rx_active_d;
      rx_prev_level_q <= rx_prev_level_d;
      rx_result_q     <= rx_result_d;
    end
  end

  always_comb begin
    result_o.tx_line  = tx_level_d;
    result_o.tx_busy  = tx_active_d;
    result_o.rx_busy  = rx_active_d;
    result_o.rx_valid = rx_valid;
    result_o.rx_byte  = ByteWidth'(rx_result_d);
  end

endmodule

// ----- sv/half_duplex_uart_8n1.sv -----
// A tick's result is registered at the edge that accepts the tick: into the output
// register, or into the skid entry while the output register is stalled.
// Throughput: one tick per cycle while the skid entry is empty; the next-state logic
// of both engines is one pass; the two-entry buffer takes one more tick in a stall.
// Reset (rst_ni low, asynchronous) idles both directions with the line high,
// empties the output buffer and restores the bit period to 104 ticks.
module half_duplex_uart_8n1
  import hdu_pkg::*;
#(
  parameter int unsigned DATA_BITS          = DataBitsDefault,
  parameter int unsigned TICK_COUNTER_WIDTH = CntWidthDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [BaudDivWidth-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    rx_level_i,
  input  logic                    send_valid_i,
  input  logic [ByteWidth-1:0]    send_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    tx_line_o,
  output logic                    tx_busy_o,
  output logic                    rx_busy_o,
  output logic                    rx_valid_o,
  output logic [ByteWidth-1:0]    rx_byte_o
);

  logic [BaudDivWidth-1:0] baud_div_q;
  hdu_result_t             result;
  hdu_result_t             out_q, out_d, skid_q, skid_d;
  logic                    out_valid_q, out_valid_d;
  logic                    skid_valid_q, skid_valid_d;
  logic                    in_fire;
  logic                    out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_div_q <= BaudDivReset;
    end else if (cfg_valid_i) begin
      baud_div_q <= cfg_data_i;
    end
  end

  hdu_engine #(
    .DATA_BITS         (DATA_BITS),
    .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .baud_div_i  (baud_div_q),
    .rx_level_i  (rx_level_i),
    .send_valid_i(send_valid_i),
    .send_data_i (send_data_i),
    .result_o    (result)
  );

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = in_fire;
        skid_d       = result;
      end else begin
        out_valid_d = in_fire;
        out_d       = result;
      end
    end else if (in_fire) begin
      skid_d       = result;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign tx_line_o   = out_q.tx_line;
  assign tx_busy_o   = out_q.tx_busy;
  assign rx_busy_o   = out_q.rx_busy;
  assign rx_valid_o  = out_q.rx_valid;
  assign rx_byte_o   = out_q.rx_byte;

  // The skid entry is only ever filled behind a waiting output entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) skid_valid_q |-> out_valid_q)
    else $error("skid entry holds data while the output register is empty");

  // Transmit and receive never overlap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o |-> !(tx_busy_o && rx_busy_o))
    else $error("transmitter and receiver busy at the same time");

  // A completed byte always ends the reception.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && rx_valid_o) |-> !rx_busy_o)
    else $error("receiver still busy on a completed byte");

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hdu_pkg::*;

  localparam int unsigned ClkPeriod   = 10;
  localparam int unsigned ResetCycles = 8;
  localparam int unsigned BaudDivMin  = 2;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned PrintCap    = 40;

  class tick_scoreboard;
    logic [BaudDivWidth-1:0]    baud_div;
    logic [ByteWidth-1:0]       tx_shift;
    logic [3:0]                 tx_bits_left;
    logic                       tx_next_level;
    logic [CntWidthDefault-1:0] tx_count;
    logic                       tx_level;
    bit                         tx_active;
    logic [ByteWidth-1:0]       rx_shift;
    logic [3:0]                 rx_index;
    logic [CntWidthDefault-1:0] rx_count;
    bit                         rx_active;
    logic                       rx_prev;
    logic [ByteWidth-1:0]       rx_result;
    hdu_result_t                pending_outputs[$];
    int unsigned                errors;
    int unsigned                checked;

    function new();
      baud_div      = BaudDivReset;
      tx_shift      = '0;
      tx_bits_left  = '0;
      tx_next_level = 1'b0;
      tx_count      = '0;
      tx_level      = 1'b1;
      tx_active     = 1'b0;
      rx_shift      = '0;
      rx_index      = '0;
      rx_count      = '0;
      rx_active     = 1'b0;
      rx_prev       = 1'b1;
      rx_result     = '0;
      errors        = 0;
      checked       = 0;
    endfunction

    // Advances both directions by one accepted tick and queues the outputs it yields.
    function void note_tick(logic level, logic send, logic [ByteWidth-1:0] data);
      bit          tx_was_active;
      bit          taken;
      logic        done;
      hdu_result_t outputs;
      tx_was_active = tx_active;
      taken         = 1'b0;
      done          = 1'b0;
      if (tx_active) begin
        tx_count = tx_count - 1'b1;
        if (tx_count == '0) begin
          tx_level = tx_next_level;
          if (tx_bits_left == '0) begin
            tx_active     = 1'b0;
            tx_next_level = 1'b0;
          end else begin
            tx_next_level = tx_shift[0] | (tx_bits_left <= 4'd2);
            tx_shift      = tx_shift >> 1;
            tx_bits_left  = tx_bits_left - 1'b1;
            tx_count      = baud_div;
          end
        end
      end else if (send) begin
        taken         = 1'b1;
        tx_active     = 1'b1;
        tx_shift      = data;
        tx_bits_left  = 4'(DataBitsDefault + 2);
        tx_next_level = 1'b0;
        tx_count      = CntWidthDefault'(TxStartDelay);
        rx_active     = 1'b0;
      end
      if (!taken) begin
        if (rx_active) begin
          rx_count = rx_count - 1'b1;
          if (rx_count == '0) begin
            if (rx_index < 4'(DataBitsDefault)) begin
              if (level) rx_shift[rx_index[2:0]] = 1'b1;
              rx_index = rx_index + 1'b1;
              rx_count = baud_div;
            end else begin
              rx_result = rx_shift;
              done      = 1'b1;
              rx_active = 1'b0;
            end
          end
        end else if (!tx_was_active && !tx_active && rx_prev && !level) begin
          rx_active = 1'b1;
          rx_shift  = '0;
          rx_index  = '0;
          rx_count  = baud_div + (baud_div >> 1);
        end
      end
      rx_prev = level;
      outputs.tx_line  = tx_level;
      outputs.tx_busy  = tx_active;
      outputs.rx_busy  = rx_active;
      outputs.rx_valid = done;
      outputs.rx_byte  = rx_result;
      pending_outputs.push_back(outputs);
    endfunction

    task report(string field, logic [15:0] want, logic [15:0] got);
      errors++;
      if (errors <= PrintCap) begin
        $display("result %0d: %s expected %0h, got %0h", checked, field, want, got);
      end
    endtask

    task check_outputs(hdu_result_t got);
      hdu_result_t want;
      checked++;
      if (pending_outputs.size() == 0) begin
        report("unexpected result", '0, 16'(got));
        return;
      end
      want = pending_outputs.pop_front();
      if (got.tx_line !== want.tx_line) begin
        report("tx_line", 16'(want.tx_line), 16'(got.tx_line));
      end
      if (got.tx_busy !== want.tx_busy) begin
        report("tx_busy", 16'(want.tx_busy), 16'(got.tx_busy));
      end
      if (got.rx_busy !== want.rx_busy) begin
        report("rx_busy", 16'(want.rx_busy), 16'(got.rx_busy));
      end
      if (got.rx_valid !== want.rx_valid) begin
        report("rx_valid", 16'(want.rx_valid), 16'(got.rx_valid));
      end
      if (got.rx_byte !== want.rx_byte) begin
        report("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
      end
    endtask
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [BaudDivWidth-1:0] cfg_data_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    rx_level_i;
  logic                    send_valid_i;
  logic [ByteWidth-1:0]    send_data_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic                    tx_line_o;
  logic                    tx_busy_o;
  logic                    rx_busy_o;
  logic                    rx_valid_o;
  logic [ByteWidth-1:0]    rx_byte_o;

  tick_scoreboard sb;
  bit             in_gaps;
  bit             out_gaps;
  bit             hold_out;
  int unsigned    ticks_in_phase;

  half_duplex_uart_8n1 u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_level_i  (rx_level_i),
    .send_valid_i(send_valid_i),
    .send_data_i (send_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .tx_line_o   (tx_line_o),
    .tx_busy_o   (tx_busy_o),
    .rx_busy_o   (rx_busy_o),
    .rx_valid_o  (rx_valid_o),
    .rx_byte_o   (rx_byte_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_tick(rx_level_i, send_valid_i, send_data_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_outputs({tx_line_o, tx_busy_o, rx_busy_o, rx_valid_o, rx_byte_o});
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_out = 1'b0;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 3)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic put_tick(input logic level, input logic send, input logic [ByteWidth-1:0] data);
    if (in_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    rx_level_i   <= level;
    send_valid_i <= send;
    send_data_i  <= data;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    ticks_in_phase++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending_outputs.size() != 0);
  endtask

  task automatic write_baud_div(input logic [BaudDivWidth-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.baud_div = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle_line();
    while (sb.tx_active || sb.rx_active) put_tick(1'b1, 1'b0, 8'($urandom));
  endtask

  task automatic drive_rx_frame(input int unsigned bt, input logic [ByteWidth-1:0] frame_data,
                                input int abort_at, input int unsigned stop_ticks);
    int unsigned k;
    repeat ($urandom_range(1, bt)) put_tick(1'b1, 1'b0, 8'($urandom));
    for (k = 0; k < 9 * bt; k++) begin
      put_tick((k < bt) ? 1'b0 : frame_data[k / bt - 1], int'(k) == abort_at, 8'($urandom));
    end
    repeat (stop_ticks) put_tick(1'b1, 1'b0, 8'($urandom));
  endtask

  task automatic run_send(input int unsigned bt, input logic [ByteWidth-1:0] data);
    put_tick(1'b1, 1'b1, data);
    repeat ($urandom_range(8 * bt, 12 * bt + 12)) begin
      put_tick(1'($urandom_range(0, 1)), $urandom_range(0, 7) == 0, 8'($urandom));
    end
  endtask

  task automatic run_mixed(input int unsigned bt, input int unsigned budget, input bit pressure,
                           input bit gaps);
    int unsigned pick;
    bit          held;
    bit          paused;
    held           = 1'b0;
    paused         = 1'b0;
    ticks_in_phase = 0;
    while (ticks_in_phase < budget || (pressure && !paused)) begin
      if (gaps && $urandom_range(0, 3) == 0) begin
        in_gaps  = $urandom_range(0, 2) != 0;
        out_gaps = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if (sb.tx_active && $urandom_range(0, 3) != 0) settle_line();
        drive_rx_frame(bt, 8'($urandom),
                       (pick < 55) ? -1 : int'($urandom_range(0, 9 * bt - 1)),
                       $urandom_range(1, 3 * bt));
      end else if (pick < 80) begin
        run_send(bt, 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 3 * bt)) begin
          put_tick(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0, 8'($urandom));
        end
      end
      if (pressure && !held && ticks_in_phase >= 10) begin
        hold_out = 1'b1;
        held     = 1'b1;
      end else if (pressure && held && !paused && ticks_in_phase >= 20) begin
        wait_drained();
        paused = 1'b1;
      end
    end
    settle_line();
    wait_drained();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    rx_level_i   = 1'b1;
    send_valid_i = 1'b0;
    send_data_i  = '0;
    in_gaps      = 1'b1;
    out_gaps     = 1'b1;
    hold_out     = 1'b0;
    sb           = new();
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // The reset state is checked on a few idle ticks before any write.
    repeat (4) put_tick(1'b1, 1'b0, 8'($urandom));
    wait_drained();

    write_baud_div(BaudDivWidth'(BaudDivMin));
    drive_rx_frame(BaudDivMin, 8'hFF, -1, 2);
    // A falling edge on the tick that completes a reception must not start another one.
    drive_rx_frame(BaudDivMin, 8'h80, -1, 1);
    repeat (4) put_tick(1'b0, 1'b0, 8'($urandom));
    repeat (4) put_tick(1'b1, 1'b0, 8'($urandom));
    drive_rx_frame(BaudDivMin, 8'h5A, -1, 2);
    // A request held high is ignored while busy and on the final tick of a transfer.
    put_tick(1'b1, 1'b1, 8'hFF);
    repeat (2 * (TxStartDelay + 11 * BaudDivMin) + 6) begin
      put_tick(1'($urandom_range(0, 1)), 1'b1, 8'($urandom));
    end
    settle_line();
    drive_rx_frame(BaudDivMin, 8'hC3, 9, 3);
    settle_line();
    put_tick(1'b1, 1'b1, 8'h00);
    settle_line();
    wait_drained();

    run_mixed(BaudDivMin, 30, 1'b1, 1'b1);
    write_baud_div(16'd3);
    run_mixed(3, 30, 1'b0, 1'b1);
    write_baud_div(16'd5);
    run_mixed(5, 30, 1'b0, 1'b1);

    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    write_baud_div(BaudDivWidth'(BaudDivMin));
    run_mixed(BaudDivMin, 20, 1'b0, 1'b0);
    repeat (4) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_outputs.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("testbench failed");
    $finish;
  end

endmodule
